/* rtl/kara_pkg.sv */
`default_nettype none

package kara_pkg;

  // Operand width at its default value
  localparam int unsigned WidthDef = 32;

  // Port widths fixed by the interface
  localparam int unsigned OpW   = 32;
  localparam int unsigned ProdW = 64;

  // Register stages: split, sub-products, middle term, combine
  localparam int unsigned NumStages = 4;

  // Per-stage load enables from the top level's flow control
  typedef struct packed {
    logic split;
    logic mul;
    logic mid;
    logic comb;
  } kara_adv_t;

endpackage

`default_nettype wire

/* rtl/kara_datapath.sv */
`default_nettype none

module kara_datapath #(
  parameter int unsigned WIDTH = kara_pkg::WidthDef
) (
  input  wire logic                        clk_i,
  input  wire kara_pkg::kara_adv_t         adv_i,
  input  wire logic [kara_pkg::OpW-1:0]    multiplicand_i,
  input  wire logic [kara_pkg::OpW-1:0]    multiplier_i,
  output logic      [kara_pkg::ProdW-1:0]  product_o
);

  // high half H bits, low half S bits (S >= H)
  localparam int unsigned H     = WIDTH / 2;
  localparam int unsigned S     = WIDTH - H;
  localparam int unsigned SumW  = S + 1;
  localparam int unsigned P1W   = 2 * H;
  localparam int unsigned P2W   = 2 * S;
  localparam int unsigned P3W   = 2 * SumW;
  localparam int unsigned PW    = 2 * WIDTH;

  logic [WIDTH-1:0] a, b;

  logic [H-1:0]    ah_q, bh_q;
  logic [S-1:0]    al_q, bl_q;
  logic [SumW-1:0] sa_d, sb_d, sa_q, sb_q;

  logic [P1W-1:0] p1_d, p1_q, p1m_q;
  logic [P2W-1:0] p2_d, p2_q, p2m_q;
  logic [P3W-1:0] p3_d, p3_q;
  logic [P3W-1:0] mid_d, mid_q;

  logic [PW-1:0]  sum_d;
  logic [PW-1:0]  prod_q;

  // stage 1: split and half sums
  assign a    = multiplicand_i[WIDTH-1:0];
  assign b    = multiplier_i[WIDTH-1:0];
  assign sa_d = SumW'(a[WIDTH-1:S]) + SumW'(a[S-1:0]);
  assign sb_d = SumW'(b[WIDTH-1:S]) + SumW'(b[S-1:0]);

  always_ff @(posedge clk_i) begin
    if (adv_i.split) begin
      ah_q <= a[WIDTH-1:S];
      al_q <= a[S-1:0];
      bh_q <= b[WIDTH-1:S];
      bl_q <= b[S-1:0];
      sa_q <= sa_d;
      sb_q <= sb_d;
    end
  end

  // stage 2: three sub-products
  assign p1_d = ah_q * bh_q;
  assign p2_d = al_q * bl_q;
  assign p3_d = sa_q * sb_q;

  always_ff @(posedge clk_i) begin
    if (adv_i.mul) begin
      p1_q <= p1_d;
      p2_q <= p2_d;
      p3_q <= p3_d;
    end
  end

  // stage 3: cross term ah*bl + al*bh, never negative
  assign mid_d = p3_q - P3W'(p1_q) - P3W'(p2_q);

  always_ff @(posedge clk_i) begin
    if (adv_i.mid) begin
      p1m_q <= p1_q;
      p2m_q <= p2_q;
      mid_q <= mid_d;
    end
  end

  // stage 4: p1<<2S and p2 do not overlap, so they concatenate
  assign sum_d = {p1m_q, p2m_q} + (PW'(mid_q) << S);

  always_ff @(posedge clk_i) begin
    if (adv_i.comb) begin
      prod_q <= sum_d;
    end
  end

  assign product_o = kara_pkg::ProdW'(prod_q);

endmodule

`default_nettype wire

/* rtl/karatsuba_multiplier_top.sv */
`default_nettype none

// Karatsuba multiplier, pipelined.
//
// Input channel: in_valid_i / in_stall_o carry one beat of two unsigned
// operands, multiplicand_i and multiplier_i; only their low WIDTH bits count.
// Output channel: out_valid_o / out_stall_i carry one beat holding the full
// unsigned product_o, zero-extended to 64 bits. Results leave in input order.
//
// Each operand is split once into a high half of WIDTH/2 bits and a low half;
// three narrow sub-products (high*high, low*low, half-sum*half-sum) are
// formed in parallel and recombined. Four register stages: split, multiply,
// middle term, combine. Throughput is one beat per cycle while the output
// is not stalled.
//
// out_stall_i holds the output register; upstream stages keep filling any
// empty slots, so in_stall_o rises only when all four stages hold data and
// the output is stalled. Reset clears every stage's valid bit; payload
// registers are not reset.

module karatsuba_multiplier_top #(
  parameter int unsigned WIDTH = kara_pkg::WidthDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [kara_pkg::OpW-1:0]    multiplicand_i,
  input  wire logic [kara_pkg::OpW-1:0]    multiplier_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic      [kara_pkg::ProdW-1:0]  product_o
);

  localparam int unsigned N = kara_pkg::NumStages;

  logic [N-1:0] vld_d, vld_q;
  logic [N-1:0] rdy;
  kara_pkg::kara_adv_t adv;

  // a stage may load when it is empty or its content moves on
  always_comb begin
    rdy[N-1] = !vld_q[N-1] || !out_stall_i;
    for (int k = N - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  always_comb begin
    vld_d = vld_q;
    if (rdy[0]) begin
      vld_d[0] = in_valid_i;
    end
    for (int k = 1; k < N; k++) begin
      if (rdy[k]) begin
        vld_d[k] = vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign adv.split = rdy[0];
  assign adv.mul   = rdy[1];
  assign adv.mid   = rdy[2];
  assign adv.comb  = rdy[3];

  kara_datapath #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .adv_i          (adv),
    .multiplicand_i (multiplicand_i),
    .multiplier_i   (multiplier_i),
    .product_o      (product_o)
  );

  assign in_stall_o  = !rdy[0];
  assign out_valid_o = vld_q[N-1];

endmodule

`default_nettype wire

/* rtl/kara_checker.sv */
`default_nettype none

module kara_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_stall_o,
  input wire logic [kara_pkg::OpW-1:0]    multiplicand_i,
  input wire logic [kara_pkg::OpW-1:0]    multiplier_i,
  input wire logic                        out_valid_o,
  input wire logic                        out_stall_i,
  input wire logic [kara_pkg::ProdW-1:0]  product_o
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // stalled output beat stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(product_o))
    else $error("output beat changed while stalled");

  // input backpressure only when the output is blocked
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with output free");

  // with the output flowing, an accepted beat reaches the output after passing every stage
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !out_stall_i ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i
      |=> out_valid_o)
    else $error("result missing after pipeline latency");

  // a product of zero operands is zero
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && multiplicand_i == '0 && multiplier_i == '0 && !out_stall_i
      ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i
      |=> product_o == '0)
    else $error("nonzero product for zero operands");

endmodule

bind karatsuba_multiplier_top kara_checker u_kara_checker (.*);

`default_nettype wire
